// ===== rtl/skw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skw_pkg - shared types and constants for the spline kernel weight block
// Coefficient table, denominators, reciprocals and pipeline tag type.
// ----------------------------------------------------------------------------
package skw_pkg;

    localparam int DIST_W      = 16;   // distance port width
    localparam int MAG_W       = 17;   // |distance| incl. the 8.0 corner
    localparam int WEIGHT_W    = 18;   // weight port width
    localparam int COEF_W      = 14;   // signed coefficient numerators
    localparam int DEN_W       = 12;   // largest denominator is 2911
    localparam int KSEL_W      = 2;
    localparam int TAPS_W      = 3;
    localparam int SAT_SHIFT   = 17;   // quotient saturates at 2^17
    localparam int Q_W         = 18;   // quotient 0 .. 2^17
    localparam int R_W         = 29;   // clamped dividend <= den * 2^17
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 27;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int DEN_SPLINE16 = 15;
    localparam int DEN_SPLINE36 = 209;
    localparam int DEN_SPLINE64 = 2911;

    localparam logic [RECIP_W-1:0] RECIP_SPLINE16 =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DEN_SPLINE16);
    localparam logic [RECIP_W-1:0] RECIP_SPLINE36 =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DEN_SPLINE36);
    localparam logic [RECIP_W-1:0] RECIP_SPLINE64 =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DEN_SPLINE64);

    localparam logic [Q_W-1:0]      Q_SAT = Q_W'(1) << SAT_SHIFT;
    localparam logic [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};

    // register word index (byte address / 4)
    localparam logic [APB_ADDR_W-3:0] REG_KSEL = '0;

    typedef enum logic [KSEL_W-1:0] {
        KSEL_SPLINE16 = 2'd0,
        KSEL_SPLINE36 = 2'd1,
        KSEL_SPLINE64 = 2'd2
    } ksel_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    // c3 is the highest-order term (Horner start)
    typedef struct packed {
        coef_t c3;
        coef_t c2;
        coef_t c1;
        coef_t c0;
    } seg_coef_t;

    // control that travels with each request down the pipe
    typedef struct packed {
        logic              valid;
        logic              zero;   // outside support or reserved kernel
        logic              neg;    // sign of the numerator
        logic [KSEL_W-1:0] ksel;
    } skw_tag_t;

    function automatic seg_coef_t mk_seg(input int a, input int b, input int c,
                                         input int d);
        seg_coef_t s;
        s.c3 = COEF_W'(a);
        s.c2 = COEF_W'(b);
        s.c1 = COEF_W'(c);
        s.c0 = COEF_W'(d);
        return s;
    endfunction

    function automatic seg_coef_t skw_coef(input logic [KSEL_W-1:0] ksel,
                                           input logic [1:0] segment);
        seg_coef_t s;
        s = '0;
        case (ksel)
            KSEL_SPLINE16:
            begin
                case (segment)
                    2'd0:    s = mk_seg(15, -27, -3, 15);
                    2'd1:    s = mk_seg(-5, 12, -7, 0);
                    default: s = '0;
                endcase
            end
            KSEL_SPLINE36:
            begin
                case (segment)
                    2'd0:    s = mk_seg(247, -453, -3, 209);
                    2'd1:    s = mk_seg(-114, 270, -156, 0);
                    2'd2:    s = mk_seg(19, -45, 26, 0);
                    default: s = '0;
                endcase
            end
            KSEL_SPLINE64:
            begin
                case (segment)
                    2'd0:    s = mk_seg(3479, -6387, -3, 2911);
                    2'd1:    s = mk_seg(-1704, 4032, -2328, 0);
                    2'd2:    s = mk_seg(426, -1008, 582, 0);
                    2'd3:    s = mk_seg(-71, 168, -97, 0);
                    default: s = '0;
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [DEN_W-1:0] skw_den(input logic [KSEL_W-1:0] ksel);
        logic [DEN_W-1:0] d;
        case (ksel)
            KSEL_SPLINE36: d = DEN_W'(DEN_SPLINE36);
            KSEL_SPLINE64: d = DEN_W'(DEN_SPLINE64);
            default:       d = DEN_W'(DEN_SPLINE16);
        endcase
        return d;
    endfunction

    // must pair with skw_den for every code
    function automatic logic [RECIP_W-1:0] skw_recip(input logic [KSEL_W-1:0] ksel);
        logic [RECIP_W-1:0] m;
        case (ksel)
            KSEL_SPLINE36: m = RECIP_SPLINE36;
            KSEL_SPLINE64: m = RECIP_SPLINE64;
            default:       m = RECIP_SPLINE16;
        endcase
        return m;
    endfunction

    // reserved code has no taps, so every distance falls outside support
    function automatic logic [TAPS_W-1:0] skw_taps(input logic [KSEL_W-1:0] ksel);
        logic [TAPS_W-1:0] t;
        case (ksel)
            KSEL_SPLINE16: t = TAPS_W'(2);
            KSEL_SPLINE36: t = TAPS_W'(3);
            KSEL_SPLINE64: t = TAPS_W'(4);
            default:       t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/skw_horner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skw_horner - segment decode and exact cubic evaluation
// Stage A splits |distance| into segment and fraction and fetches the
// coefficients; stages B..D run one Horner step each.
// ----------------------------------------------------------------------------
module skw_horner
    import skw_pkg::*;
#(
    parameter int IN_FRAC_BITS = 12
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  wire logic signed [DIST_W-1:0]            distance,
    input  wire logic [KSEL_W-1:0]                   ksel,
    output skw_tag_t                                 out_tag,
    output logic signed [3*IN_FRAC_BITS+17:0]        n3
);

    localparam int F    = IN_FRAC_BITS;
    localparam int P1_W = COEF_W + F + 1;
    localparam int N1_W = P1_W + 1;
    localparam int N2_W = N1_W + F + 1;
    localparam int N3_W = N2_W + F + 1;

    // stage A
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  kf;
    skw_tag_t          a_tag_next, a_tag_reg;
    seg_coef_t         a_coef_next, a_coef_reg;
    logic [F-1:0]      a_tn_next, a_tn_reg;

    always_comb
    begin
        mag = distance[DIST_W-1]
            ? (MAG_W'(1) << DIST_W) - MAG_W'($unsigned(distance))
            : MAG_W'($unsigned(distance));
        kf  = mag >> F;
        a_tag_next.valid = in_valid;
        a_tag_next.zero  = (kf >= MAG_W'(skw_taps(ksel)));
        a_tag_next.neg   = 1'b0;
        a_tag_next.ksel  = ksel;
        a_coef_next      = skw_coef(ksel, kf[1:0]);
        a_tn_next        = mag[F-1:0];
    end

    // stage B: c3*t + c2
    logic signed [P1_W-1:0] p1;
    logic signed [N1_W-1:0] b_n1_next, b_n1_reg;
    skw_tag_t               b_tag_reg;
    logic [F-1:0]           b_tn_reg;
    coef_t                  b_c1_reg, b_c0_reg;

    always_comb
    begin
        p1        = P1_W'($signed(a_coef_reg.c3)) * P1_W'($signed({1'b0, a_tn_reg}));
        b_n1_next = N1_W'(p1) + (N1_W'($signed(a_coef_reg.c2)) <<< F);
    end

    // stage C
    logic signed [N2_W-1:0] p2;
    logic signed [N2_W-1:0] c_n2_next, c_n2_reg;
    skw_tag_t               c_tag_reg;
    logic [F-1:0]           c_tn_reg;
    coef_t                  c_c0_reg;

    always_comb
    begin
        p2        = N2_W'(b_n1_reg) * N2_W'($signed({1'b0, b_tn_reg}));
        c_n2_next = p2 + (N2_W'($signed(b_c1_reg)) <<< (2*F));
    end

    // stage D
    logic signed [N3_W-1:0] p3;
    logic signed [N3_W-1:0] d_n3_next, d_n3_reg;
    skw_tag_t               d_tag_reg;

    always_comb
    begin
        p3        = N3_W'(c_n2_reg) * N3_W'($signed({1'b0, c_tn_reg}));
        d_n3_next = p3 + (N3_W'($signed(c_c0_reg)) <<< (3*F));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
            c_tag_reg <= '0;
            d_tag_reg <= '0;
        end
        else if (adv)
        begin
            a_tag_reg <= a_tag_next;
            b_tag_reg <= a_tag_reg;
            c_tag_reg <= b_tag_reg;
            d_tag_reg <= c_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_coef_reg <= a_coef_next;
            a_tn_reg   <= a_tn_next;
            b_n1_reg   <= b_n1_next;
            b_tn_reg   <= a_tn_reg;
            b_c1_reg   <= a_coef_reg.c1;
            b_c0_reg   <= a_coef_reg.c0;
            c_n2_reg   <= c_n2_next;
            c_tn_reg   <= b_tn_reg;
            c_c0_reg   <= b_c0_reg;
            d_n3_reg   <= d_n3_next;
        end
    end

    assign out_tag = d_tag_reg;
    assign n3      = d_n3_reg;

endmodule
`default_nettype wire

// ===== rtl/skw_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skw_scale - round-to-nearest division by the kernel denominator
// Magnitude, rounding offset and clamp, then reciprocal multiply with a
// one-step remainder correction.
// ----------------------------------------------------------------------------
module skw_scale
    import skw_pkg::*;
#(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire skw_tag_t                            in_tag,
    input  wire logic signed [3*IN_FRAC_BITS+17:0]   n3,
    output skw_tag_t                                 out_tag,
    output logic [Q_W-1:0]                           q
);

    localparam int N3_W   = 3*IN_FRAC_BITS + 18;
    localparam int TRIPLE = 3*IN_FRAC_BITS;
    localparam int SL     = (OUT_FRAC_BITS > TRIPLE) ? OUT_FRAC_BITS - TRIPLE : 0;
    localparam int SR     = (TRIPLE > OUT_FRAC_BITS) ? TRIPLE - OUT_FRAC_BITS : 0;
    localparam int SUM_W  = N3_W + SL + 1;
    localparam int PROD_W = R_W + RECIP_W;
    localparam int QD_W   = Q_W + DEN_W;

    // stage E: magnitude
    skw_tag_t         e_tag_next, e_tag_reg;
    logic [N3_W-1:0]  e_an_next, e_an_reg;

    always_comb
    begin
        e_tag_next     = in_tag;
        e_tag_next.neg = n3[N3_W-1];
        e_an_next      = n3[N3_W-1] ? N3_W'(-n3) : N3_W'(n3);
    end

    // stage F: add half the divisor, drop the scale, clamp at 2^17 * den
    logic [DEN_W-1:0] e_den;
    logic [SUM_W-1:0] num, r_full;
    logic [R_W-1:0]   limit;
    logic [R_W-1:0]   f_r_next, f_r_reg;
    skw_tag_t         f_tag_reg;

    always_comb
    begin
        e_den    = skw_den(e_tag_reg.ksel);
        num      = (SUM_W'(e_an_reg) << SL) + ((SUM_W'(e_den) << SR) >> 1);
        r_full   = num >> SR;
        limit    = R_W'(e_den) << SAT_SHIFT;
        f_r_next = (r_full > SUM_W'(limit)) ? limit : R_W'(r_full);
    end

    // stage G: quotient estimate, low by at most one
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    g_qe_next, g_qe_reg;
    logic [R_W-1:0]    g_r_reg;
    skw_tag_t          g_tag_reg;

    always_comb
    begin
        prod      = PROD_W'(f_r_reg) * PROD_W'(skw_recip(f_tag_reg.ksel));
        g_qe_next = Q_W'(prod >> RECIP_SHIFT);
    end

    // stage H: estimate times divisor
    logic [QD_W-1:0]  h_qd_next, h_qd_reg;
    logic [Q_W-1:0]   h_qe_reg;
    logic [R_W-1:0]   h_r_reg;
    skw_tag_t         h_tag_reg;

    always_comb
    begin
        h_qd_next = QD_W'(g_qe_reg) * QD_W'(skw_den(g_tag_reg.ksel));
    end

    // stage I: correct by one if remainder still holds a divisor
    logic [R_W-1:0]   rem;
    logic [Q_W-1:0]   i_q_next, i_q_reg;
    skw_tag_t         i_tag_reg;

    always_comb
    begin
        rem      = h_r_reg - R_W'(h_qd_reg);
        i_q_next = h_qe_reg + Q_W'(rem >= R_W'(skw_den(h_tag_reg.ksel)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_tag_reg <= '0;
            f_tag_reg <= '0;
            g_tag_reg <= '0;
            h_tag_reg <= '0;
            i_tag_reg <= '0;
        end
        else if (adv)
        begin
            e_tag_reg <= e_tag_next;
            f_tag_reg <= e_tag_reg;
            g_tag_reg <= f_tag_reg;
            h_tag_reg <= g_tag_reg;
            i_tag_reg <= h_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_an_reg <= e_an_next;
            f_r_reg  <= f_r_next;
            g_qe_reg <= g_qe_next;
            g_r_reg  <= f_r_reg;
            h_qd_reg <= h_qd_next;
            h_qe_reg <= g_qe_reg;
            h_r_reg  <= g_r_reg;
            i_q_reg  <= i_q_next;
        end
    end

    assign out_tag = i_tag_reg;
    assign q       = i_q_reg;

endmodule
`default_nettype wire

// ===== rtl/spline_kernel_weight.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spline_kernel_weight - Spline16/36/64 resampling kernel weight
// Signed Q3.12 distance in, signed Q1.16 weight out, kernel chosen by a
// configuration register.
// ----------------------------------------------------------------------------
//
//  channel   handshake                    payload          direction
//  --------  ---------------------------  ---------------  ---------
//  request   dist_valid / dist_ready      distance [15:0]  in
//  result    weight_valid / weight_ready  weight [17:0]    out
//  config    APB psel/penable/pwrite      kernel_select    in/out
//
//  One request per clock while weight_ready does not stall the pipe; the pipe
//  has 1 decode stage, 3 Horner stages, 5 divide/round stages, 1 output register.
//  The whole pipe advances together: it moves when the output register is
//  empty or being taken, so dist_ready follows weight_ready the same cycle.
//  A stall freezes every stage; nothing is dropped or repeated.
//  Reset clears kernel_select (Spline16) and all stage valid bits; no
//  memories, so no clearing pass.
//
//  Datapath notes:
//   - The cubic is evaluated exactly in integers (no rounding inside
//     Horner), then divided once by den * 2^(3F - OUT_FRAC_BITS).
//   - The division by the kernel denominator uses a 2^30 reciprocal; the
//     dividend is clamped to den * 2^17 first so the estimate is off by
//     at most one, fixed by a remainder compare.
//   - Reserved kernel code and distances at or past the support give 0.
//
module spline_kernel_weight
    import skw_pkg::*;
#(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // APB configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_W-1:0]      paddr,
    input  wire logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]           prdata,
    output logic                            pready,
    // request channel
    input  wire logic                       dist_valid,
    output logic                            dist_ready,
    input  wire logic signed [DIST_W-1:0]   distance,
    // result channel
    output logic                            weight_valid,
    input  wire logic                       weight_ready,
    output logic signed [WEIGHT_W-1:0]      weight
);

    localparam int N3_W = 3*IN_FRAC_BITS + 18;

    // ---------------- configuration ----------------
    logic [KSEL_W-1:0]       kernel_select_reg;
    logic                    cfg_wr;
    logic [APB_ADDR_W-3:0]   reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_wr    = psel && penable && pwrite && (reg_index == REG_KSEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kernel_select_reg <= KSEL_SPLINE16;
        else if (cfg_wr)
            kernel_select_reg <= pwdata[KSEL_W-1:0];
    end

    assign prdata = (reg_index == REG_KSEL)
                  ? APB_DATA_W'(kernel_select_reg) : '0;

    // ---------------- pipeline control ----------------
    logic adv;
    logic weight_valid_reg;

    // global advance: output slot free or being drained
    assign adv        = !weight_valid_reg || weight_ready;
    assign dist_ready = adv;

    // ---------------- datapath ----------------
    skw_tag_t                horner_tag;
    logic signed [N3_W-1:0]  horner_n3;
    skw_tag_t                scale_tag;
    logic [Q_W-1:0]          scale_q;

    skw_horner #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_horner (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (dist_valid),
        .distance (distance),
        .ksel     (kernel_select_reg),
        .out_tag  (horner_tag),
        .n3       (horner_n3)
    );

    skw_scale #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_tag  (horner_tag),
        .n3      (horner_n3),
        .out_tag (scale_tag),
        .q       (scale_q)
    );

    // ---------------- sign, saturate, output register ----------------
    logic [WEIGHT_W-1:0] weight_next, weight_reg;

    always_comb
    begin
        if (scale_tag.zero)
            weight_next = '0;
        else if (scale_tag.neg)
            weight_next = WEIGHT_W'(-scale_q);       // q <= 2^17 fits
        else if (WEIGHT_W'(scale_q) > W_MAX)
            weight_next = W_MAX;
        else
            weight_next = WEIGHT_W'(scale_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_valid_reg <= 1'b0;
        else if (adv)
            weight_valid_reg <= scale_tag.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            weight_reg <= weight_next;
    end

    assign weight_valid = weight_valid_reg;
    assign weight       = $signed(weight_reg);

    // ---------------- assertions ----------------
    // stalled pipe must hold the divider result
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(scale_q) && $stable(scale_tag))
        else $error("divider stage changed during stall");

    // clamp plus correction keeps the quotient within 2^17
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scale_tag.valid |-> scale_q <= Q_SAT)
        else $error("quotient beyond saturation bound");

    // register write lands
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> kernel_select_reg == $past(pwdata[KSEL_W-1:0]))
        else $error("kernel_select write lost");

endmodule
`default_nettype wire
